@@ rtl/upq_pkg.sv @@
// shared types, codes and constants of the unordered priority queue
package upq_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int DATA_W       = 32;
  localparam int OCC_W        = 7;

  localparam logic [1:0] CMD_ENQUEUE = 2'd0;
  localparam logic [1:0] CMD_DEL_MAX = 2'd1;
  localparam logic [1:0] CMD_DEL_MIN = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic        [1:0]        command;
    logic signed [DATA_W-1:0] item_value;
    logic signed [DATA_W-1:0] item_priority;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] removed_value;
    logic        [1:0]        status;
    logic        [OCC_W-1:0]  occupancy;
    logic                     queue_empty;
  } out_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] rank;
  } entry_t;

  typedef enum logic [1:0] {
    OP_HOLD  = 2'd0,
    OP_LOAD  = 2'd1,
    OP_SHIFT = 2'd2,
    OP_WRAP  = 2'd3
  } cell_op_t;

endpackage

@@ rtl/upq_cell.sv @@
// one storage cell of the entry chain
module upq_cell (
  input  logic              clk,
  input  upq_pkg::cell_op_t op,
  input  upq_pkg::entry_t   load_i,
  input  upq_pkg::entry_t   next_i,
  input  upq_pkg::entry_t   head_i,
  output upq_pkg::entry_t   entry_o
);

  upq_pkg::entry_t entry_r;

  always_ff @(posedge clk) begin
    unique case (op)
      upq_pkg::OP_LOAD:  entry_r <= load_i;
      upq_pkg::OP_SHIFT: entry_r <= next_i;
      upq_pkg::OP_WRAP:  entry_r <= head_i;
      default:           entry_r <= entry_r;
    endcase
  end

  assign entry_o = entry_r;

endmodule

@@ rtl/unordered_priority_queue.sv @@
// top level: chain of entry cells with scan and compaction control
//
// Usage: drive in_item and raise start; a command is taken at a clock edge where
// start is high and busy is low. Every command gives exactly one result beat on
// out_result, marked by out_valid for one cycle, in the cycle after the command
// finishes. The receiver cannot stall, so results are never held back.
// Enqueue, a refused enqueue, a delete on an empty queue and the unused command
// code finish in the accepting cycle: the result follows in the next cycle, busy
// stays low and a new command may follow in the next cycle.
// A delete rotates the occupied part of the cell chain once around, one cell a
// cycle, while the entry at cell 0 is compared against the running extreme, then
// closes the gap in the compaction state. Busy stays high through the rotation
// and the compaction, and the result beat follows the compaction; the rotation
// length, set by the occupancy, decides how long a delete keeps busy high.
// Reset empties the queue; the cell contents are not cleared and are only read
// below the fill count. Occupancy and the empty flag report the state after the
// command.
module unordered_priority_queue #(
  parameter int CAPACITY = upq_pkg::CAPACITY_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  upq_pkg::in_t   in_item,
  output logic           out_valid,
  output upq_pkg::out_t  out_result
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE    = 3'b001,
    S_SCAN    = 3'b010,
    S_COMPACT = 3'b100
  } state_t;

  state_t                           state_r, state_nxt;
  logic [CW-1:0]                    count_r, count_nxt;
  logic [IW-1:0]                    step_r, step_nxt;
  logic [IW-1:0]                    best_idx_r, best_idx_nxt;
  logic signed [upq_pkg::DATA_W-1:0] best_pri_r, best_pri_nxt;
  logic signed [upq_pkg::DATA_W-1:0] best_val_r, best_val_nxt;
  logic                             del_max_r, del_max_nxt;
  logic                             out_valid_r, out_valid_nxt;
  upq_pkg::out_t                    out_r, out_nxt;

  upq_pkg::entry_t   cell_q  [CAPACITY];
  upq_pkg::cell_op_t cell_op [CAPACITY];
  upq_pkg::entry_t   load_entry;

  logic          accept;
  logic          enq_ok;
  logic [CW-1:0] last_pos;
  logic          take;

  assign accept   = start && (state_r == S_IDLE);
  assign enq_ok   = accept && (in_item.command == upq_pkg::CMD_ENQUEUE)
                    && (count_r != CW'(CAPACITY));
  assign last_pos = count_r - CW'(1);

  assign load_entry.value = in_item.item_value;
  assign load_entry.rank  = in_item.item_priority;

  // first beat of the rotation always seeds the running extreme
  always_comb begin
    if (step_r == '0) begin
      take = 1'b1;
    end else if (del_max_r) begin
      take = cell_q[0].rank > best_pri_r;
    end else begin
      take = cell_q[0].rank < best_pri_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    step_nxt      = step_r;
    best_idx_nxt  = best_idx_r;
    best_pri_nxt  = best_pri_r;
    best_val_nxt  = best_val_r;
    del_max_nxt   = del_max_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          out_nxt.removed_value = '0;
          out_nxt.status        = upq_pkg::ST_OK;
          unique case (in_item.command) inside
            upq_pkg::CMD_ENQUEUE: begin
              out_valid_nxt = 1'b1;
              if (count_r == CW'(CAPACITY)) begin
                out_nxt.status = upq_pkg::ST_FULL;
              end else begin
                count_nxt = count_r + CW'(1);
              end
            end
            upq_pkg::CMD_DEL_MAX, upq_pkg::CMD_DEL_MIN: begin
              if (count_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_nxt.status = upq_pkg::ST_EMPTY;
              end else begin
                state_nxt   = S_SCAN;
                step_nxt    = '0;
                del_max_nxt = (in_item.command == upq_pkg::CMD_DEL_MAX);
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (take) begin
          best_idx_nxt = step_r;
          best_pri_nxt = cell_q[0].rank;
          best_val_nxt = cell_q[0].value;
        end
        step_nxt = step_r + IW'(1);
        if (CW'(step_r) == last_pos) begin
          state_nxt = S_COMPACT;
        end
      end
      S_COMPACT: begin
        count_nxt             = last_pos;
        out_valid_nxt         = 1'b1;
        out_nxt.removed_value = best_val_r;
        out_nxt.status        = upq_pkg::ST_OK;
        state_nxt             = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (out_valid_nxt) begin
      out_nxt.occupancy   = upq_pkg::OCC_W'(count_nxt);
      out_nxt.queue_empty = (count_nxt == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r     <= step_nxt;
    best_idx_r <= best_idx_nxt;
    best_pri_r <= best_pri_nxt;
    best_val_r <= best_val_nxt;
    del_max_r  <= del_max_nxt;
    out_r      <= out_nxt;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    upq_pkg::entry_t next_entry;

    if (i < CAPACITY - 1) begin : g_mid
      assign next_entry = cell_q[i+1];
    end else begin : g_end
      assign next_entry = cell_q[i];
    end

    // occupied cells rotate toward cell 0 during the scan, the gap closes after
    always_comb begin
      cell_op[i] = upq_pkg::OP_HOLD;
      if (enq_ok && (CW'(i) == count_r)) begin
        cell_op[i] = upq_pkg::OP_LOAD;
      end else if (state_r == S_SCAN) begin
        if (CW'(i) == last_pos) begin
          cell_op[i] = upq_pkg::OP_WRAP;
        end else if (CW'(i) < last_pos) begin
          cell_op[i] = upq_pkg::OP_SHIFT;
        end
      end else if (state_r == S_COMPACT) begin
        if ((CW'(i) >= CW'(best_idx_r)) && (CW'(i) < last_pos)) begin
          cell_op[i] = upq_pkg::OP_SHIFT;
        end
      end
    end

    upq_cell u_cell (
      .clk     (clk),
      .op      (cell_op[i]),
      .load_i  (load_entry),
      .next_i  (next_entry),
      .head_i  (cell_q[0]),
      .entry_o (cell_q[i])
    );
  end

  assign busy       = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_result = out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("fill count above capacity");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_result.queue_empty == (out_result.occupancy == '0)))
    else $error("empty flag disagrees with occupancy");

  a_enq_count: assert property (@(posedge clk) disable iff (!rst_n)
    enq_ok |=> (count_r == $past(count_r) + CW'(1)))
    else $error("enqueue did not grow the fill count");

  a_del_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COMPACT) |=> (out_valid && (count_r == $past(count_r) - CW'(1))))
    else $error("delete did not shrink the queue with a result beat");

endmodule

@@ dv/testbench.sv @@
// self-checking testbench for the unordered priority queue: directed edge cases and random traffic
`timescale 1ns / 1ps

module testbench;
  import upq_pkg::*;

  // command code 3 is not defined by the block and must act as a no-op
  localparam logic [1:0] CMD_NOP = 2'd3;
  localparam int DEPTH = CAPACITY_DEF;
  localparam int IDLE_LIMIT = 2000;
  localparam int TAIL_CYCLES = DEPTH + 8;
  localparam int MIX_TARGET = 800;
  localparam int MAX_LOGGED = 40;
  localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7fff_ffff;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_item;
  logic out_valid;
  out_t out_result;

  // reference copy of the table, oldest entry first
  logic signed [DATA_W-1:0] held_values[$];
  logic signed [DATA_W-1:0] held_ranks[$];
  out_t pending_results[$];

  bit no_gaps;
  int items_sent;
  int mismatch_count;
  int idle_cycles;
  int n_enqueued, n_refused, n_deleted, n_empty_deletes, n_nops, peak_occupancy;

  unordered_priority_queue uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  task automatic log_mismatch(string msg);
    if (mismatch_count < MAX_LOGGED) $display("mismatch at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // applies one command to the reference table and returns the result it must give
  function automatic out_t apply_command(in_t item);
    out_t res;
    int pick;
    res = '0;
    res.status = ST_OK;
    case (item.command)
      CMD_ENQUEUE: begin
        if (held_values.size() >= DEPTH) begin
          res.status = ST_FULL;
          n_refused++;
        end else begin
          held_values.push_back(item.item_value);
          held_ranks.push_back(item.item_priority);
          n_enqueued++;
        end
      end
      CMD_DEL_MAX, CMD_DEL_MIN: begin
        if (held_values.size() == 0) begin
          res.status = ST_EMPTY;
          n_empty_deletes++;
        end else begin
          // strict compare keeps the earliest entry on a tie
          pick = 0;
          for (int i = 1; i < held_ranks.size(); i++) begin
            if (item.command == CMD_DEL_MAX ? held_ranks[i] > held_ranks[pick]
                                            : held_ranks[i] < held_ranks[pick])
              pick = i;
          end
          res.removed_value = held_values[pick];
          held_values.delete(pick);
          held_ranks.delete(pick);
          n_deleted++;
        end
      end
      default: n_nops++;
    endcase
    res.occupancy = OCC_W'(held_values.size());
    res.queue_empty = (held_values.size() == 0);
    if (held_values.size() > peak_occupancy) peak_occupancy = held_values.size();
    return res;
  endfunction

  function automatic in_t make_item(logic [1:0] cmd, logic signed [DATA_W-1:0] value,
                                    logic signed [DATA_W-1:0] rank);
    in_t it;
    it.command = cmd;
    it.item_value = value;
    it.item_priority = rank;
    return it;
  endfunction

  function automatic in_t random_item(int enq_pct);
    in_t it;
    int roll;
    it.item_value = $urandom;
    // narrow ranks and the word extremes make ties common
    case ($urandom_range(0, 9))
      0: it.item_priority = WORD_MIN;
      1: it.item_priority = WORD_MAX;
      2, 3, 4, 5: it.item_priority = 32'($urandom_range(0, 8)) - 32'sd4;
      default: it.item_priority = $urandom;
    endcase
    roll = $urandom_range(0, 99);
    if (roll < 2) it.command = CMD_NOP;
    else if (roll < enq_pct) it.command = CMD_ENQUEUE;
    else it.command = $urandom_range(0, 1) ? CMD_DEL_MAX : CMD_DEL_MIN;
    return it;
  endfunction

  task automatic send_item(in_t item);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 17);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    in_item <= item;
    do @(posedge clk); while (busy);
    pending_results.push_back(apply_command(item));
    if (item.command != CMD_NOP) items_sent++;
  endtask

  // drops start and holds off until every outstanding result has come back
  task automatic pause_until_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_queue();
    send_item(make_item(CMD_DEL_MAX, $urandom, $urandom));
    send_item(make_item(CMD_DEL_MIN, $urandom, $urandom));
    send_item(make_item(CMD_NOP, $urandom, $urandom));
    pause_until_drained();
  endtask

  task automatic test_extremes_and_ties();
    no_gaps = 1'b0;
    send_item(make_item(CMD_ENQUEUE, WORD_MAX, WORD_MIN));
    send_item(make_item(CMD_ENQUEUE, WORD_MIN, WORD_MIN));
    send_item(make_item(CMD_ENQUEUE, 32'sd0, WORD_MAX));
    send_item(make_item(CMD_ENQUEUE, -32'sd1, WORD_MAX));
    send_item(make_item(CMD_ENQUEUE, 32'sd1, 32'sd0));
    send_item(make_item(CMD_NOP, $urandom, $urandom));
    send_item(make_item(CMD_DEL_MAX, $urandom, $urandom));
    send_item(make_item(CMD_DEL_MIN, $urandom, $urandom));
    send_item(make_item(CMD_DEL_MAX, $urandom, $urandom));
    send_item(make_item(CMD_DEL_MIN, $urandom, $urandom));
    send_item(make_item(CMD_DEL_MAX, $urandom, $urandom));
    // three equal ranks: min and max both take the oldest
    no_gaps = 1'b1;
    send_item(make_item(CMD_ENQUEUE, 32'sd11, 32'sd5));
    send_item(make_item(CMD_ENQUEUE, 32'sd22, 32'sd5));
    send_item(make_item(CMD_ENQUEUE, 32'sd33, 32'sd5));
    send_item(make_item(CMD_DEL_MIN, 32'sd0, 32'sd0));
    send_item(make_item(CMD_DEL_MAX, 32'sd0, 32'sd0));
    send_item(make_item(CMD_DEL_MAX, 32'sd0, 32'sd0));
    send_item(make_item(CMD_DEL_MIN, 32'sd0, 32'sd0));
    pause_until_drained();
  endtask

  task automatic test_fill_to_capacity();
    no_gaps = $urandom_range(0, 1);
    while (held_values.size() < DEPTH) send_item(random_item(90));
    repeat (3) send_item(make_item(CMD_ENQUEUE, $urandom, $urandom));
    send_item(make_item(CMD_NOP, $urandom, $urandom));
    send_item(make_item(CMD_DEL_MAX, $urandom, $urandom));
    send_item(make_item(CMD_ENQUEUE, $urandom, WORD_MAX));
    send_item(make_item(CMD_ENQUEUE, $urandom, $urandom));
    pause_until_drained();
  endtask

  task automatic test_drain_to_empty();
    no_gaps = $urandom_range(0, 1);
    while (held_values.size() > 0) send_item(random_item(10));
    send_item(make_item(CMD_DEL_MIN, $urandom, $urandom));
    send_item(make_item(CMD_DEL_MAX, $urandom, $urandom));
    pause_until_drained();
  endtask

  task automatic test_random_mix();
    int enq_pct;
    while (items_sent < MIX_TARGET) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      enq_pct = $urandom_range(25, 75);
      repeat (40) send_item(random_item(enq_pct));
      if ($urandom_range(0, 7) == 0) pause_until_drained();
    end
    pause_until_drained();
  endtask

  always @(posedge clk) begin : check_results
    out_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        log_mismatch("result beat with nothing expected");
      end else begin
        want = pending_results.pop_front();
        if (out_result.removed_value !== want.removed_value)
          log_mismatch($sformatf("removed_value got %0d want %0d",
                                 out_result.removed_value, want.removed_value));
        if (out_result.status !== want.status)
          log_mismatch($sformatf("status got %0d want %0d", out_result.status, want.status));
        if (out_result.occupancy !== want.occupancy)
          log_mismatch($sformatf("occupancy got %0d want %0d",
                                 out_result.occupancy, want.occupancy));
        if (out_result.queue_empty !== want.queue_empty)
          log_mismatch($sformatf("queue_empty got %0b want %0b",
                                 out_result.queue_empty, want.queue_empty));
      end
    end
  end

  // ends the run if neither a command nor a result beat moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    no_gaps = 1'b0;
    items_sent = 0;
    mismatch_count = 0;
    idle_cycles = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_queue();
    test_extremes_and_ties();
    test_fill_to_capacity();
    test_drain_to_empty();
    test_random_mix();
    test_fill_to_capacity();
    test_drain_to_empty();

    pause_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      log_mismatch($sformatf("%0d results never arrived", pending_results.size()));

    $display("covered %0d commands: %0d enqueues, %0d refused when full, %0d deletes",
             items_sent + n_nops, n_enqueued, n_refused, n_deleted);
    $display("%0d deletes on an empty queue, %0d no-ops, peak occupancy %0d, %0d mismatches",
             n_empty_deletes, n_nops, peak_occupancy, mismatch_count);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
